[hw/rtl/psalu_pkg.sv]
// Shared types and constants for the postfix stack ALU.
package psalu_pkg;

    localparam int WORD_W  = 32;
    localparam int IDX_W   = 10;
    localparam int DEPTH_W = 11;
    localparam int STEP_W  = $clog2(WORD_W);

    typedef enum logic [2:0] {
        CMD_PUSH        = 3'd0,
        CMD_POP         = 3'd1,
        CMD_PEEK_TOP    = 3'd2,
        CMD_PEEK_BOTTOM = 3'd3,
        CMD_ADD         = 3'd4,
        CMD_SUB         = 3'd5,
        CMD_MUL         = 3'd6,
        CMD_DIV         = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_EMPTY   = 3'd1,
        ERR_RANGE   = 3'd2,
        ERR_FEW     = 3'd3,
        ERR_DIVZERO = 3'd4,
        ERR_FULL    = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

[hw/rtl/postfix_stack_alu.sv]
// Top level of the postfix stack ALU: command sequencer, stack store and shared unit.
//
// One command is taken when start is high and busy is low; its single result shows on
// value, error and depth for one cycle with done high, and a new command may be taken in
// that same cycle. Push and commands rejected up front end in the decode state, pop
// and peek after one read of the stack store, divide by zero after the second read,
// the rest in the shared unit. The stack store is one RAM with a registered read port,
// so the two operands are fetched one after another, and multiply and divide run 32
// steps plus one result step (sign fix for divide). The receiver cannot stall.
module postfix_stack_alu import psalu_pkg::*; #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                command,
    input  logic signed [WORD_W-1:0]  operand,
    input  logic [IDX_W-1:0]          index,
    output logic                      done,
    output logic signed [WORD_W-1:0]  value,
    output logic [2:0]                error,
    output logic [DEPTH_W-1:0]        depth
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int XW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int OW    = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ_A = 5'b00100,
        S_READ_B = 5'b01000,
        S_EXEC   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    cmd_t              cmd_reg, cmd_next;
    logic [WORD_W-1:0] operand_reg, operand_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] value_reg, value_next;
    err_t              error_reg, error_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] wdata, rd_data;

    alu_req_t          alu_req;
    logic              alu_done;
    logic [WORD_W-1:0] alu_result;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [XW-1:0]     cnt_x, idx_x, top_addr_x;
    logic [OW-1:0]     cnt_o;

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign cnt_m2     = count_reg - CNT_W'(2);
    assign cnt_x      = XW'(count_reg);
    assign idx_x      = XW'(index_reg);
    assign top_addr_x = cnt_x - idx_x - XW'(1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        cmd_next     = cmd_reg;
        operand_next = operand_reg;
        index_next   = index_reg;
        a_next       = a_reg;
        value_next   = value_reg;
        error_next   = error_reg;
        we           = 1'b0;
        waddr        = cnt_m2[AW-1:0];
        wdata        = alu_result;
        raddr        = cnt_m1[AW-1:0];
        alu_req      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd_t'(command);
                    operand_next = operand;
                    index_next   = index;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_READ_A;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        done_next  = 1'b1;
                        value_next = '0;
                        state_next = S_IDLE;
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            error_next = ERR_FULL;
                        end
                        else
                        begin
                            error_next = ERR_OK;
                            we         = 1'b1;
                            waddr      = count_reg[AW-1:0];
                            wdata      = operand_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            done_next  = 1'b1;
                            value_next = '0;
                            error_next = ERR_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            count_next = cnt_m1;
                        end
                    end
                    CMD_PEEK_TOP, CMD_PEEK_BOTTOM:
                    begin
                        if (idx_x >= cnt_x)
                        begin
                            done_next  = 1'b1;
                            value_next = '0;
                            error_next = ERR_RANGE;
                            state_next = S_IDLE;
                        end
                        else if (cmd_reg == CMD_PEEK_TOP)
                        begin
                            raddr = top_addr_x[AW-1:0];
                        end
                        else
                        begin
                            raddr = idx_x[AW-1:0];
                        end
                    end
                    default:
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            done_next  = 1'b1;
                            value_next = '0;
                            error_next = ERR_FEW;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ_A:
            begin
                if (cmd_reg inside {CMD_POP, CMD_PEEK_TOP, CMD_PEEK_BOTTOM})
                begin
                    done_next  = 1'b1;
                    value_next = rd_data;
                    error_next = ERR_OK;
                    state_next = S_IDLE;
                end
                else
                begin
                    a_next     = rd_data;
                    raddr      = cnt_m2[AW-1:0];
                    state_next = S_READ_B;
                end
            end
            S_READ_B:
            begin
                if (cmd_reg == CMD_DIV && a_reg == '0)
                begin
                    // divisor is dropped, dividend stays
                    count_next = cnt_m1;
                    done_next  = 1'b1;
                    value_next = '0;
                    error_next = ERR_DIVZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    case (cmd_reg)
                        CMD_ADD: alu_req.op = ALU_ADD;
                        CMD_SUB: alu_req.op = ALU_SUB;
                        CMD_MUL: alu_req.op = ALU_MUL;
                        default: alu_req.op = ALU_DIV;
                    endcase
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (alu_done)
                begin
                    we         = 1'b1;
                    count_next = cnt_m1;
                    done_next  = 1'b1;
                    value_next = alu_result;
                    error_next = ERR_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        operand_reg <= operand_next;
        index_reg   <= index_next;
        a_reg       <= a_next;
        value_reg   <= value_next;
        error_reg   <= error_next;
    end

    psalu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    psalu_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (a_reg),
        .b      (rd_data),
        .done   (alu_done),
        .result (alu_result)
    );

    assign cnt_o = OW'(count_reg);
    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign value = value_reg;
    assign error = error_reg;
    assign depth = cnt_o[DEPTH_W-1:0];

endmodule

[hw/rtl/psalu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module psalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/psalu_alu.sv]
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, floor divide.
module psalu_alu import psalu_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_RUN  = 3'b010,
        U_FIX  = 3'b100
    } ustate_t;

    ustate_t           state_reg, state_next;
    logic              done_reg, done_next;
    alu_op_t           op_reg, op_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] sh_reg, sh_next;
    logic [WORD_W-1:0] opd_reg, opd_next;
    logic [WORD_W-1:0] result_reg, result_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] abs_a, abs_b;

    assign abs_a = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
    assign abs_b = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
    // restoring divide step: remainder shifted with next dividend bit, minus divisor
    assign trial = {acc_reg, sh_reg[WORD_W-1]} - {1'b0, opd_reg};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        opd_next    = opd_reg;
        result_next = result_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    step_next = '0;
                    acc_next  = '0;
                    case (req.op)
                        ALU_ADD:
                        begin
                            result_next = b + a;
                            done_next   = 1'b1;
                        end
                        ALU_SUB:
                        begin
                            result_next = b - a;
                            done_next   = 1'b1;
                        end
                        ALU_MUL:
                        begin
                            sh_next    = a;
                            opd_next   = b;
                            state_next = U_RUN;
                        end
                        default:
                        begin
                            sh_next    = abs_b;
                            opd_next   = abs_a;
                            neg_next   = a[WORD_W-1] ^ b[WORD_W-1];
                            state_next = U_RUN;
                        end
                    endcase
                end
            end
            U_RUN:
            begin
                if (op_reg == ALU_MUL)
                begin
                    if (sh_reg[0])
                    begin
                        acc_next = acc_reg + opd_reg;
                    end
                    opd_next = {opd_reg[WORD_W-2:0], 1'b0};
                    sh_next  = {1'b0, sh_reg[WORD_W-1:1]};
                end
                else if (!trial[WORD_W])
                begin
                    acc_next = trial[WORD_W-1:0];
                    sh_next  = {sh_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[WORD_W-2:0], sh_reg[WORD_W-1]};
                    sh_next  = {sh_reg[WORD_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(WORD_W - 1))
                begin
                    state_next = U_FIX;
                end
            end
            U_FIX:
            begin
                if (op_reg == ALU_MUL)
                begin
                    result_next = acc_reg;
                end
                else if (neg_reg)
                begin
                    // signs differ: negate, and round down when a remainder is left
                    result_next = (acc_reg != '0) ? ~sh_reg : (WORD_W'(0) - sh_reg);
                end
                else
                begin
                    result_next = sh_reg;
                end
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        opd_reg    <= opd_next;
        result_reg <= result_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hw/rtl/psalu_checker.sv]
// Port-level assertions for the postfix stack ALU, bound to the top level.
module psalu_checker import psalu_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic signed [WORD_W-1:0] value,
    input logic [2:0]               error
);

    // result cycle is the first idle cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // a transfer never completes in the next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("transfer not followed by busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error != ERR_OK) |-> (value == '0))
        else $error("nonzero value with error");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (error <= ERR_FULL))
        else $error("undefined error code");

endmodule

bind postfix_stack_alu psalu_checker u_psalu_checker (.*);
